>>> sv/lz10_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz10_pkg
// Shared constants and the result item type of the LZ10 stream decompressor.
// ----------------------------------------------------------------------------
package lz10_pkg;

  localparam int BYTE_W = 8;   // compressed and decoded byte width
  localparam int SIZE_W = 24;  // output size register and byte counter
  localparam int DIST_W = 13;  // match distance, 12 bits plus one
  localparam int CNT_W  = 4;   // flag bit counter

  // match length is the token's high nibble plus this bias
  localparam int LEN_BIAS = 3;

  // a full flag counter means the next byte is a flag byte
  localparam logic [CNT_W-1:0] FLAG_CNT_FULL = 4'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              byte_valid;
    logic              run_last;
    logic              stream_end;
    logic              overflow;
    logic              truncated;
  } lz10_res_t;

endpackage

>>> sv/lz10_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz10_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lz10_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lz10_stream_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz10_stream_decompressor
// LZ10 (LZSS) body decoder with a ring window held in one block RAM.
// ----------------------------------------------------------------------------
// Compressed bytes enter one item at a time into a one-entry input register,
// which takes a new byte whenever it is empty. The register frees only when
// its byte is decoded, so a new byte enters only after the last one has been
// decoded. A flag byte or the first byte of a match token gives no result
// unless it carries in_last. A literal gives one result. After the second
// byte of a match, every copied byte passes through S_COPY_RD, which reads
// the window RAM, and then S_COPY_WR, which writes the byte back and
// presents it. The window RAM's single read port with registered data sets
// this order; a copy at distance one always reads the byte written just
// before it. A result waits in an output register, and the decoder stalls
// only when that register is still full. Configuration writes are taken in
// any cycle; write out_size only while the block is idle.
// ----------------------------------------------------------------------------
module lz10_stream_decompressor #(
  parameter int WINDOW_BYTES = 4096,
  parameter int MAX_MATCH    = 18
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lz10_pkg::SIZE_W-1:0] cfg_out_size,
  // compressed input
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lz10_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_last,
  // decoded output
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lz10_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_byte_valid,
  output logic                       out_run_last,
  output logic                       out_stream_end,
  output logic                       out_overflow,
  output logic                       out_truncated
);

  import lz10_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int LW = $clog2(MAX_MATCH + 1);
  localparam logic [AW-1:0] WP_RESET = AW'(WINDOW_BYTES - MAX_MATCH);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_COPY_RD = 2'd1;
  localparam logic [1:0] S_COPY_WR = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [BYTE_W-1:0] flag_bits_r, flag_bits_nxt;
  logic [CNT_W-1:0]  flag_cnt_r, flag_cnt_nxt;
  logic              phase_r, phase_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [LW-1:0]     copy_left_r, copy_left_nxt;
  logic              last_pend_r, last_pend_nxt;

  logic              inq_valid_r;
  logic [BYTE_W-1:0] inq_byte_r;
  logic              inq_last_r;
  logic              inq_take;

  logic              out_valid_r;
  lz10_res_t         res_r, res;
  logic              out_free;
  logic              emit;
  logic              byte_emit;
  logic [BYTE_W-1:0] byte_val;
  logic              restart;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  logic [4:0]        len_raw;
  logic [LW-1:0]     len;
  logic [DIST_W-1:0] match_dist;
  logic [AW+DIST_W-1:0] dist_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = !inq_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_byte       = res_r.data;
  assign out_byte_valid = res_r.byte_valid;
  assign out_run_last   = res_r.run_last;
  assign out_stream_end = res_r.stream_end;
  assign out_overflow   = res_r.overflow;
  assign out_truncated  = res_r.truncated;

  // match token decode: held byte is the first token byte
  assign len_raw    = {1'b0, held_r[7:4]} + 5'(LEN_BIAS);
  assign len        = (len_raw > 5'(MAX_MATCH)) ? LW'(MAX_MATCH) : LW'(len_raw);
  assign match_dist = DIST_W'({held_r[3:0], inq_byte_r}) + DIST_W'(1);
  assign dist_ext   = (AW + DIST_W)'(match_dist);

  lz10_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(WINDOW_BYTES)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rd_addr_nxt   = rd_addr_r;
    flag_bits_nxt = flag_bits_r;
    flag_cnt_nxt  = flag_cnt_r;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    copy_left_nxt = copy_left_r;
    last_pend_nxt = last_pend_r;
    inq_take      = 1'b0;
    emit          = 1'b0;
    byte_emit     = 1'b0;
    byte_val      = inq_byte_r;
    restart       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = inq_byte_r;
    res           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (inq_valid_r && out_free) begin
          inq_take = 1'b1;
          if (phase_r) begin
            // second match byte: start the copy
            copy_left_nxt = len;
            rd_addr_nxt   = wp_r - dist_ext[AW-1:0];
            last_pend_nxt = inq_last_r;
            phase_nxt     = 1'b0;
            state_nxt     = S_COPY_RD;
          end else if (flag_cnt_r == FLAG_CNT_FULL) begin
            flag_bits_nxt = inq_byte_r;
            flag_cnt_nxt  = '0;
            if (inq_last_r) begin
              emit           = 1'b1;
              res.run_last   = 1'b1;
              res.stream_end = 1'b1;
              restart        = 1'b1;
            end
          end else begin
            flag_bits_nxt = {flag_bits_r[BYTE_W-2:0], 1'b0};
            flag_cnt_nxt  = flag_cnt_r + CNT_W'(1);
            if (flag_bits_r[BYTE_W-1]) begin
              held_nxt  = inq_byte_r;
              phase_nxt = 1'b1;
              if (inq_last_r) begin
                // stream cut inside a match token
                emit           = 1'b1;
                res.run_last   = 1'b1;
                res.stream_end = 1'b1;
                res.truncated  = 1'b1;
                restart        = 1'b1;
              end
            end else begin
              ram_we         = 1'b1;
              wp_nxt         = wp_r + AW'(1);
              emit           = 1'b1;
              byte_emit      = 1'b1;
              res.run_last   = 1'b1;
              res.stream_end = inq_last_r;
              restart        = inq_last_r;
            end
          end
        end
      end
      S_COPY_RD: begin
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        if (out_free) begin
          ram_we        = 1'b1;
          ram_wdata     = ram_rdata;
          byte_val      = ram_rdata;
          wp_nxt        = wp_r + AW'(1);
          rd_addr_nxt   = rd_addr_r + AW'(1);
          copy_left_nxt = copy_left_r - LW'(1);
          emit          = 1'b1;
          byte_emit     = 1'b1;
          if (copy_left_r == LW'(1)) begin
            res.run_last   = 1'b1;
            res.stream_end = last_pend_r;
            restart        = last_pend_r;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_COPY_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // decoded bytes past out_size are dropped but still kept in the window
    if (byte_emit) begin
      if (cnt_r < size_r) begin
        cnt_nxt        = cnt_r + SIZE_W'(1);
        res.data       = byte_val;
        res.byte_valid = 1'b1;
      end else begin
        res.overflow = 1'b1;
      end
    end

    if (restart) begin
      wp_nxt        = WP_RESET;
      flag_bits_nxt = '0;
      flag_cnt_nxt  = FLAG_CNT_FULL;
      phase_nxt     = 1'b0;
      held_nxt      = '0;
      cnt_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= WP_RESET;
      rd_addr_r   <= '0;
      flag_bits_r <= '0;
      flag_cnt_r  <= FLAG_CNT_FULL;
      phase_r     <= 1'b0;
      held_r      <= '0;
      cnt_r       <= '0;
      size_r      <= '0;
      copy_left_r <= '0;
      last_pend_r <= 1'b0;
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rd_addr_r   <= rd_addr_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_cnt_r  <= flag_cnt_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      copy_left_r <= copy_left_nxt;
      last_pend_r <= last_pend_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_out_size;
      end
      if (in_valid && in_ready) begin
        inq_valid_r <= 1'b1;
      end else if (inq_take) begin
        inq_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r <= in_byte;
      inq_last_r <= in_last;
    end
    if (emit) begin
      res_r <= res;
    end
  end

  a_flag_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    flag_cnt_r <= FLAG_CNT_FULL)
    else $error("flag counter beyond a full flag byte");

  a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY_RD || state_r == S_COPY_WR) |-> copy_left_r != '0)
    else $error("copy running with no bytes left");

  a_copy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY_WR && out_free && copy_left_r == LW'(1)) |=>
      state_r == S_IDLE && out_valid_r && res_r.run_last)
    else $error("final copied byte did not close the match");

  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.byte_valid && res_r.overflow))
    else $error("byte both valid and overflowed");

  a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.truncated) |-> (res_r.stream_end && !res_r.byte_valid))
    else $error("truncation flagged away from stream end");

endmodule
